[src/mpc_pkg.sv]
// Shared types and constants for the message packetizer with checksum.
// Used by every module in src; no dependencies of its own.
package mpc_pkg;

   localparam int BYTE_W          = 8;     // message byte
   localparam int IDX_W           = 10;    // reported byte index
   localparam int CNT_OUT_W       = 11;    // reported payload count
   localparam int SUM_W           = 19;    // checksum width, wraps
   localparam int TERM_W          = 10;    // one byte's checksum term, signed
   localparam int MAX_PAYLOAD_DEF = 1024;  // default packet payload limit

   localparam logic KIND_DATA = 1'b0;      // packet in the middle of a message
   localparam logic KIND_LAST = 1'b1;      // packet that closes the message

   typedef struct packed {
      logic [BYTE_W-1:0] msg_byte;
      logic              final_byte;
   } in_item_type;

endpackage

[src/message_packetizer_checksum_unit.sv]
// Top level of the message packetizer with per-packet checksum.
// Depends on mpc_pkg, mpc_in_reg and mpc_term.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid req_stall req_msg_byte        | in
//           | req_final_byte                          |
//   rsp     | rsp_valid rsp_stall rsp_payload_byte    | out
//           | rsp_byte_index rsp_packet_done          |
//           | rsp_packet_kind rsp_payload_count       |
//           | rsp_packet_sum                          |
//
// One item in, one item out, one item per cycle sustained while rsp is not
// stalled. An accepted item is loaded into the input register and moves on into
// the result register, which raises rsp_valid, once that is empty or draining.
// The per-byte add into the running checksum forms the loop through sum_ff.
// Reset is synchronous and clears the valids, the byte counter and the sum.
// A stall on rsp holds the result register and backs up into req_stall in the
// same cycle once the input register is also full.
module message_packetizer_checksum_unit #(
   parameter int MAX_PAYLOAD = mpc_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mpc_pkg::BYTE_W-1:0]           req_msg_byte,
   input  logic                                 req_final_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mpc_pkg::BYTE_W-1:0]           rsp_payload_byte,
   output logic [mpc_pkg::IDX_W-1:0]            rsp_byte_index,
   output logic                                 rsp_packet_done,
   output logic                                 rsp_packet_kind,
   output logic [mpc_pkg::CNT_OUT_W-1:0]        rsp_payload_count,
   output logic signed [mpc_pkg::SUM_W-1:0]     rsp_packet_sum
);

   // Counter holds 0..MAX_PAYLOAD-1; its increment reaches MAX_PAYLOAD.
   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int EXT_W = (CNT_W > mpc_pkg::CNT_OUT_W) ? CNT_W : mpc_pkg::CNT_OUT_W;

   mpc_pkg::in_item_type req_item;
   mpc_pkg::in_item_type s1_item;
   logic                 s1_valid;
   logic                 s2_load;

   logic [CNT_W-1:0]                    count_ff;
   logic [CNT_W-1:0]                    count_in;
   logic signed [mpc_pkg::SUM_W-1:0]    sum_ff;
   logic signed [mpc_pkg::SUM_W-1:0]    sum_in;

   logic [CNT_W-1:0]                    count_next;
   logic [EXT_W-1:0]                    pos_ext;
   logic [EXT_W-1:0]                    count_ext;
   logic signed [mpc_pkg::TERM_W-1:0]   term;
   logic signed [mpc_pkg::SUM_W-1:0]    sum_next;
   logic                                done;

   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [mpc_pkg::BYTE_W-1:0]          payload_byte_ff;
   logic [mpc_pkg::IDX_W-1:0]           byte_index_ff;
   logic                                packet_done_ff;
   logic                                packet_kind_ff;
   logic [mpc_pkg::CNT_OUT_W-1:0]       payload_count_ff;
   logic signed [mpc_pkg::SUM_W-1:0]    packet_sum_ff;

   assign req_item.msg_byte   = req_msg_byte;
   assign req_item.final_byte = req_final_byte;

   // Result register takes a new item whenever it is empty or being drained.
   assign s2_load = s1_valid && (!rsp_valid_ff || !rsp_stall);

   mpc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .take      (s2_load),
      .out_valid (s1_valid),
      .out_item  (s1_item)
   );

   mpc_term u_term (
      .byte_in (s1_item.msg_byte),
      .grp_pos (count_ff[1:0]),
      .term    (term)
   );

   // Advance the packet position and the running checksum.
   assign count_next = count_ff + CNT_W'(1);
   assign sum_next   = sum_ff
                     + {{(mpc_pkg::SUM_W-mpc_pkg::TERM_W){term[mpc_pkg::TERM_W-1]}}, term};
   assign done       = s1_item.final_byte || (count_next >= CNT_W'(MAX_PAYLOAD));
   assign pos_ext    = EXT_W'(count_ff);
   assign count_ext  = EXT_W'(count_next);

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (s2_load) begin
         // Drop back to an empty packet when this byte closes one.
         count_in = done ? '0 : count_next;
         sum_in   = done ? '0 : sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_comb begin
      priority if (s2_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Header fields read zero on bytes that close nothing.
   always_ff @(posedge clock) begin
      if (s2_load) begin
         payload_byte_ff  <= s1_item.msg_byte;
         byte_index_ff    <= pos_ext[mpc_pkg::IDX_W-1:0];
         packet_done_ff   <= done;
         packet_kind_ff   <= (done && s1_item.final_byte) ? mpc_pkg::KIND_LAST
                                                          : mpc_pkg::KIND_DATA;
         payload_count_ff <= done ? count_ext[mpc_pkg::CNT_OUT_W-1:0] : '0;
         packet_sum_ff    <= done ? sum_next : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_byte  = payload_byte_ff;
   assign rsp_byte_index    = byte_index_ff;
   assign rsp_packet_done   = packet_done_ff;
   assign rsp_packet_kind   = packet_kind_ff;
   assign rsp_payload_count = payload_count_ff;
   assign rsp_packet_sum    = packet_sum_ff;

   // The open packet never holds a full payload between items.
   assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_W'(MAX_PAYLOAD))
      else $error("packet byte counter reached the payload limit");

   // Closing a packet empties the counter and the running sum.
   assert property (@(posedge clock) disable iff (reset)
      (s2_load && done) |=> (count_ff == '0 && sum_ff == '0))
      else $error("packet state not cleared after packet close");

   // A byte that closes nothing carries an all-zero header.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_packet_done) |->
         (rsp_packet_kind == mpc_pkg::KIND_DATA && rsp_payload_count == '0
          && rsp_packet_sum == '0))
      else $error("header fields set on a byte that closes no packet");

   // A data packet that is not the last one is always full.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_packet_done && rsp_packet_kind == mpc_pkg::KIND_DATA) |->
         (rsp_payload_count == mpc_pkg::CNT_OUT_W'(MAX_PAYLOAD)))
      else $error("short data packet closed before end of message");

endmodule

[src/mpc_in_reg.sv]
// Input register of the packetizer: holds one item until the core takes it.
// Depends on mpc_pkg for the item type.
module mpc_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mpc_pkg::in_item_type req_item,
   input  logic                 take,
   output logic                 out_valid,
   output mpc_pkg::in_item_type out_item
);

   logic                 valid_ff;
   logic                 valid_in;
   logic                 accept;
   mpc_pkg::in_item_type item_ff;

   // Stall only while a held item cannot move on this cycle.
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[src/mpc_term.sv]
// Checksum term of one byte: times three in group slots 0 and 1,
// divided by three toward zero in slots 2 and 3. Depends on mpc_pkg.
module mpc_term (
   input  logic [mpc_pkg::BYTE_W-1:0]        byte_in,
   input  logic [1:0]                        grp_pos,
   output logic signed [mpc_pkg::TERM_W-1:0] term
);

   logic                               neg;
   logic [mpc_pkg::BYTE_W-1:0]         mag;
   logic [15:0]                        prod;
   logic [6:0]                         quot;
   logic signed [mpc_pkg::TERM_W-1:0]  val;
   logic signed [mpc_pkg::TERM_W-1:0]  triple;
   logic signed [mpc_pkg::TERM_W-1:0]  quot_ext;
   logic signed [mpc_pkg::TERM_W-1:0]  third;

   assign neg = byte_in[mpc_pkg::BYTE_W-1];
   assign mag = neg ? (mpc_pkg::BYTE_W'(0) - byte_in) : byte_in;

   // Magnitude at most 128: times 171 then shift by 9 is an exact divide by 3.
   assign prod     = 16'(mag) * 16'd171;
   assign quot     = prod[15:9];
   assign quot_ext = {{(mpc_pkg::TERM_W-7){1'b0}}, quot};
   assign third    = neg ? (mpc_pkg::TERM_W'(0) - quot_ext) : quot_ext;

   assign val    = {{(mpc_pkg::TERM_W-mpc_pkg::BYTE_W){byte_in[mpc_pkg::BYTE_W-1]}}, byte_in};
   assign triple = (val <<< 1) + val;

   assign term = grp_pos[1] ? third : triple;

endmodule

[bench/tb.sv]
// Self-checking bench for message_packetizer_checksum_unit.
// Predicts every result item as stimulus is queued; needs only mpc_pkg and the block.
module tb;

   // Run at the default payload limit so the full-packet case is hit with
   // the real counter widths.
   localparam int PKT_MAX      = mpc_pkg::MAX_PAYLOAD_DEF;
   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 12;
   localparam int IDLE_PCT     = 16;
   // Stretch of cycles with no idling on either side.
   localparam int QUIET_FROM   = 600;
   localparam int QUIET_TO     = 1800;
   localparam int SHORT_FILL   = 280;
   localparam int LONG_LEN     = PKT_MAX + PKT_MAX / 4;
   localparam int TOTAL_FILL   = 1750;
   localparam int DRAIN_CYCLES = 10;
   localparam int REPORT_MAX   = 10;
   localparam int CYCLE_LIMIT  = 200000;

   // One expected result item, laid out like the rsp ports.
   typedef struct packed {
      logic [mpc_pkg::BYTE_W-1:0]          payload_byte;
      logic [mpc_pkg::IDX_W-1:0]           byte_index;
      logic                                packet_done;
      logic                                packet_kind;
      logic [mpc_pkg::CNT_OUT_W-1:0]       payload_count;
      logic signed [mpc_pkg::SUM_W-1:0]    packet_sum;
   } pkt_out_type;

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_stall;
   logic [mpc_pkg::BYTE_W-1:0]             req_msg_byte;
   logic                                   req_final_byte;
   logic                                   rsp_valid;
   logic                                   rsp_stall;
   logic [mpc_pkg::BYTE_W-1:0]             rsp_payload_byte;
   logic [mpc_pkg::IDX_W-1:0]              rsp_byte_index;
   logic                                   rsp_packet_done;
   logic                                   rsp_packet_kind;
   logic [mpc_pkg::CNT_OUT_W-1:0]          rsp_payload_count;
   logic signed [mpc_pkg::SUM_W-1:0]       rsp_packet_sum;

   mpc_pkg::in_item_type                   byte_q[$];      // bytes still to be driven
   pkt_out_type                            packet_q[$];    // results still to arrive
   mpc_pkg::in_item_type                   next_byte;
   pkt_out_type                            want;

   // Predictor state: the packet being assembled.
   int                                     open_len;
   logic signed [mpc_pkg::SUM_W-1:0]       open_sum;

   int                                     cycle_count;
   int                                     mismatches;

   message_packetizer_checksum_unit #(
      .MAX_PAYLOAD(PKT_MAX)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_msg_byte      (req_msg_byte),
      .req_final_byte    (req_final_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_packet_done   (rsp_packet_done),
      .rsp_packet_kind   (rsp_packet_kind),
      .rsp_payload_count (rsp_payload_count),
      .rsp_packet_sum    (rsp_packet_sum)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // Idle decision for either side; never idle inside the quiet stretch.
   function automatic bit take_break();
      if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
         return 1'b0;
      return $urandom_range(99) < IDLE_PCT;
   endfunction

   // Queue one byte for the driver and predict the item it produces.
   // Group positions 0 and 1 add byte*3, positions 2 and 3 add byte/3
   // truncated toward zero; the sum wraps at SUM_W bits.
   task automatic packetize(input logic [mpc_pkg::BYTE_W-1:0] b, input logic last);
      int                               v;
      int                               term;
      logic signed [mpc_pkg::SUM_W-1:0] sum;
      pkt_out_type                      r;
      mpc_pkg::in_item_type             it;
      v = $signed(b);
      if (open_len % 4 < 2)
         term = v * 3;
      else
         term = v / 3;
      sum = mpc_pkg::SUM_W'(open_sum + term);
      r.payload_byte = b;
      r.byte_index   = open_len[mpc_pkg::IDX_W-1:0];
      if (last || open_len + 1 >= PKT_MAX) begin
         // Close the packet: header fields valid, state back to empty.
         r.packet_done   = 1'b1;
         r.packet_kind   = last ? mpc_pkg::KIND_LAST : mpc_pkg::KIND_DATA;
         r.payload_count = mpc_pkg::CNT_OUT_W'(open_len + 1);
         r.packet_sum    = sum;
         open_len        = 0;
         open_sum        = '0;
      end else begin
         // Header fields read zero on a byte that closes nothing.
         r.packet_done   = 1'b0;
         r.packet_kind   = mpc_pkg::KIND_DATA;
         r.payload_count = '0;
         r.packet_sum    = '0;
         open_len        = open_len + 1;
         open_sum        = sum;
      end
      packet_q.push_back(r);
      it.msg_byte   = b;
      it.final_byte = last;
      byte_q.push_back(it);
   endtask

   // Mostly uniform bytes, with the signed extremes mixed in.
   function automatic logic [mpc_pkg::BYTE_W-1:0] pick_byte();
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'h7F;
            2:       return 8'h80;
            default: return 8'hFF;
         endcase
      end
      return mpc_pkg::BYTE_W'($urandom_range(255));
   endfunction

   task automatic short_message();
      int len;
      if ($urandom_range(9) == 0)
         len = $urandom_range(40, 13);
      else
         len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++)
         packetize(pick_byte(), i == len - 1);
   endtask

   // Stimulus: directed messages, short random messages, one message of a
   // full packet plus a quarter, then more short messages.
   initial begin
      reset          = 1'b1;
      open_len       = 0;
      open_sum       = '0;

      // Single-byte messages at the byte extremes.
      packetize(8'h00, 1'b1);
      packetize(8'hFF, 1'b1);
      packetize(8'h7F, 1'b1);
      packetize(8'h80, 1'b1);
      // One full group of four, largest magnitudes on both halves.
      packetize(8'h7F, 1'b0);
      packetize(8'h80, 1'b0);
      packetize(8'h7F, 1'b0);
      packetize(8'h80, 1'b1);
      // Truncation toward zero for negatives, then a partial second group.
      packetize(8'h80, 1'b0);
      packetize(8'h7F, 1'b0);
      packetize(8'hFE, 1'b0);
      packetize(8'hFC, 1'b0);
      packetize(8'h05, 1'b1);
      // Trailing partial group that ends on a divided position.
      packetize(8'h01, 1'b0);
      packetize(8'h02, 1'b0);
      packetize(8'hFF, 1'b1);
      // Mixed bit patterns across two groups.
      packetize(8'h55, 1'b0);
      packetize(8'hAA, 1'b0);
      packetize(8'h03, 1'b0);
      packetize(8'hFD, 1'b0);
      packetize(8'h10, 1'b0);
      packetize(8'hEF, 1'b0);
      packetize(8'h42, 1'b1);

      while (byte_q.size() < SHORT_FILL)
         short_message();
      // A full data packet closed by the limit, then a short last packet.
      // Bias the content so the full packet's sum runs large positive and
      // the tail runs negative.
      for (int i = 0; i < LONG_LEN; i++)
         packetize(i < PKT_MAX ? mpc_pkg::BYTE_W'($urandom_range(127, 100))
                               : mpc_pkg::BYTE_W'($urandom_range(160, 128)),
                   i == LONG_LEN - 1);
      while (byte_q.size() < TOTAL_FILL)
         short_message();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Hold until every byte is accepted and every result has come back.
      while (byte_q.size() != 0 || req_valid)
         @(posedge clock);
      while (packet_q.size() != 0)
         @(posedge clock);
      // Let any stray extra result show up.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && packet_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Driver: present a new item only when the slot is empty or its item
   // is being accepted at this edge; otherwise hold the payload.
   initial begin
      req_valid      = 1'b0;
      req_msg_byte   = '0;
      req_final_byte = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (byte_q.size() != 0 && !take_break()) begin
            next_byte      = byte_q.pop_front();
            req_valid      <= 1'b1;
            req_msg_byte   <= next_byte.msg_byte;
            req_final_byte <= next_byte.final_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: drive a random stall and check each accepted result item
   // against the oldest prediction.
   initial rsp_stall = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= take_break();
         if (rsp_valid && !rsp_stall) begin
            if (packet_q.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < REPORT_MAX)
                  $display("cycle %0d: result item with none expected", cycle_count);
            end else begin
               want = packet_q.pop_front();
               if (rsp_payload_byte  !== want.payload_byte  ||
                   rsp_byte_index    !== want.byte_index    ||
                   rsp_packet_done   !== want.packet_done   ||
                   rsp_packet_kind   !== want.packet_kind   ||
                   rsp_payload_count !== want.payload_count ||
                   rsp_packet_sum    !== want.packet_sum) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < REPORT_MAX)
                     $display({"cycle %0d: mismatch byte %h/%h idx %0d/%0d done %b/%b",
                               " kind %b/%b count %0d/%0d sum %0d/%0d (expected/actual)"},
                              cycle_count,
                              want.payload_byte, rsp_payload_byte,
                              want.byte_index, rsp_byte_index,
                              want.packet_done, rsp_packet_done,
                              want.packet_kind, rsp_packet_kind,
                              want.payload_count, rsp_payload_count,
                              want.packet_sum, rsp_packet_sum);
               end
            end
         end
      end
   end

   // Cycle counter and run limit.
   initial begin
      cycle_count = 0;
      mismatches  = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
